// File: hw/rtl/sbmm_pkg.sv
`default_nettype none
package sbmm_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int VAL_W   = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic             load;
    logic             sort;
    logic             shift;
    logic             phase;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/sbmm_cell.sv
`default_nettype none
module sbmm_cell
  import sbmm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic [IDX_W-1:0]        idx_i,
  input  wire logic signed [VAL_W-1:0] load_value_i,
  input  wire logic signed [VAL_W-1:0] nbr_lo_i,
  input  wire logic signed [VAL_W-1:0] nbr_hi_i,
  output logic signed [VAL_W-1:0]      value_o
);

  logic signed [VAL_W-1:0] value_q, value_d;
  logic [IDX_W:0]          idx_w, lo_w, hi_w;
  logic                    is_lower;
  logic                    lower_ok;
  logic                    upper_ok;

  assign idx_w    = {1'b0, idx_i};
  assign lo_w     = {1'b0, ctrl_i.lo};
  assign hi_w     = {1'b0, ctrl_i.hi};
  assign is_lower = (idx_i[0] == ctrl_i.phase);

  // A pair may swap only when both of its cells lie strictly inside the span.
  assign lower_ok = (idx_w > lo_w) && ((idx_w + 1'b1) < hi_w);
  assign upper_ok = (idx_w > (lo_w + 1'b1)) && (idx_w < hi_w);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load && (ctrl_i.wr_idx == idx_i)) begin
      value_d = load_value_i;
    end else if (ctrl_i.sort) begin
      if (is_lower) begin
        if (lower_ok && (nbr_hi_i < value_q)) begin
          value_d = nbr_hi_i;
        end
      end else begin
        if (upper_ok && (value_q < nbr_lo_i)) begin
          value_d = nbr_lo_i;
        end
      end
    end else if (ctrl_i.shift) begin
      value_d = nbr_hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

// File: hw/rtl/sbmm_ctrl.sv
`default_nettype none
module sbmm_ctrl
  import sbmm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_last_i,
  input  wire logic signed [VAL_W-1:0] in_value_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         out_last_o,
  output cell_ctrl_t                   ctrl_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        phase_cnt_q, phase_cnt_d;
  logic [IDX_W-1:0]        emit_cnt_q, emit_cnt_d;
  logic [IDX_W-1:0]        min_pos_q, min_pos_d;
  logic [IDX_W-1:0]        max_pos_q, max_pos_d;
  logic signed [VAL_W-1:0] min_val_q, min_val_d;
  logic signed [VAL_W-1:0] max_val_q, max_val_d;

  logic in_xfer;
  logic out_xfer;
  logic store;
  logic sort_done;
  logic emit_last;

  assign in_xfer   = in_valid_i && (state_q == ST_LOAD);
  assign out_xfer  = (state_q == ST_EMIT) && !out_stall_i;
  assign store     = in_xfer && (count_q < CNT_W'(MAX_LEN));
  assign sort_done = (phase_cnt_q == (count_q - 1'b1));
  assign emit_last = ({1'b0, emit_cnt_q} == (count_q - 1'b1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_xfer && in_last_i) state_d = ST_SORT;
      ST_SORT: if (sort_done) state_d = ST_EMIT;
      ST_EMIT: if (out_xfer && emit_last) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_LOAD);
    out_valid_o   = (state_q == ST_EMIT);
    out_last_o    = emit_last;
    ctrl_o.load   = store;
    ctrl_o.sort   = (state_q == ST_SORT);
    ctrl_o.shift  = out_xfer;
    ctrl_o.phase  = phase_cnt_q[0];
    ctrl_o.wr_idx = count_q[IDX_W-1:0];
    ctrl_o.lo     = (min_pos_q < max_pos_q) ? min_pos_q : max_pos_q;
    ctrl_o.hi     = (min_pos_q < max_pos_q) ? max_pos_q : min_pos_q;
  end

  // Running extremes are tracked as the list arrives, so no search pass is needed.
  always_comb begin
    count_d     = count_q;
    phase_cnt_d = '0;
    emit_cnt_d  = emit_cnt_q;
    min_pos_d   = min_pos_q;
    max_pos_d   = max_pos_q;
    min_val_d   = min_val_q;
    max_val_d   = max_val_q;
    if (store) begin
      count_d = count_q + 1'b1;
      if ((count_q == '0) || (in_value_i < min_val_q)) begin
        min_val_d = in_value_i;
        min_pos_d = count_q[IDX_W-1:0];
      end
      if ((count_q == '0) || !(in_value_i < max_val_q)) begin
        max_val_d = in_value_i;
        max_pos_d = count_q[IDX_W-1:0];
      end
    end
    if (state_q == ST_SORT) begin
      phase_cnt_d = phase_cnt_q + 1'b1;
    end
    if (out_xfer) begin
      if (emit_last) begin
        emit_cnt_d = '0;
        count_d    = '0;
      end else begin
        emit_cnt_d = emit_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      phase_cnt_q <= '0;
      emit_cnt_q  <= '0;
      min_pos_q   <= '0;
      max_pos_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      phase_cnt_q <= phase_cnt_d;
      emit_cnt_q  <= emit_cnt_d;
      min_pos_q   <= min_pos_d;
      max_pos_q   <= max_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_val_q <= min_val_d;
    max_val_q <= max_val_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/sort_between_min_and_max_unit.sv
`default_nettype none
// Collects a list of signed 32-bit values, one per transfer, until a transfer
// with last set, then sorts ascending the elements lying strictly between the
// first smallest and the last largest element, and returns the whole list in
// order with last_res_o on its final element. Up to 64 elements are kept;
// further elements are dropped, though a dropped last still closes the list.
// While loading, one element is taken every cycle and the extremes are tracked
// on the fly. Sorting is an odd-even transposition pass over a row of cells,
// one pass per cycle, with as many passes as the list has elements. The
// list is then shifted out of the row at one element per cycle while the
// output is not stalled; no new list is taken until the previous one has
// been sent.
module sort_between_min_and_max_unit
  import sbmm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic                    last_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [VAL_W-1:0]      value_res_o,
  output logic                         last_res_o
);

  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] cell_val [MAX_LEN];

  sbmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (last_i),
    .in_value_i  (value_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_last_o  (last_res_o),
    .ctrl_o      (ctrl)
  );

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic signed [VAL_W-1:0] nbr_lo;
    logic signed [VAL_W-1:0] nbr_hi;

    if (i == 0) begin : g_first
      assign nbr_lo = cell_val[i];
    end else begin : g_lo
      assign nbr_lo = cell_val[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_final
      assign nbr_hi = cell_val[i];
    end else begin : g_hi
      assign nbr_hi = cell_val[i+1];
    end

    sbmm_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .idx_i        (IDX_W'(i)),
      .load_value_i (value_i),
      .nbr_lo_i     (nbr_lo),
      .nbr_hi_i     (nbr_hi),
      .value_o      (cell_val[i])
    );
  end

  assign value_res_o = cell_val[0];

endmodule
`default_nettype wire
